/* hw/rtl/dibit_slicer_sync_tuning_detector_defines.svh */
// Assertion macros shared by the checker of the dibit slicer and sync detector.
// No dependencies; take in by `include where assertions are written.
`ifndef DIBIT_SLICER_SYNC_TUNING_DETECTOR_DEFINES_SVH
`define DIBIT_SLICER_SYNC_TUNING_DETECTOR_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted
`define DSSTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles
`define DSSTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/dsstd_pkg.sv */
// Shared types and constants of the dibit slicer and sync/tuning detector.
// No dependencies; imported by the configuration block, the core and the top level.
package dsstd_pkg;

    localparam int HistW = 48;
    localparam int P2W   = 40;
    localparam int RunW  = 4;
    localparam int AddrW = 6;
    localparam int DataW = 64;

    localparam logic [RunW-1:0] RunMax = 4'd15;

    typedef enum logic [1:0] {
        KIND_SYNC  = 2'd0,
        KIND_MINUS = 2'd1,
        KIND_PLUS  = 2'd2,
        KIND_BOTH  = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        REG_TDMA_MODE   = 3'd0,
        REG_P1_MASK     = 3'd1,
        REG_P1_PATTERN  = 3'd2,
        REG_P2_MASK     = 3'd3,
        REG_P2_PATTERN  = 3'd4,
        REG_REPEAT_THR  = 3'd5
    } reg_index_t;

    // Tuning-error patterns: -1200 Hz, +1200 Hz, 2400 Hz
    localparam logic [HistW-1:0] Tune48Minus = 48'h001050551155;
    localparam logic [HistW-1:0] Tune48Plus  = 48'hFFEFAFAAEEAA;
    localparam logic [HistW-1:0] Tune48Both  = 48'hAA8A0A008800;
    localparam logic [P2W-1:0]   Tune40Minus = 40'h0104015155;
    localparam logic [P2W-1:0]   Tune40Plus  = 40'hfefbfeaeaa;
    localparam logic [P2W-1:0]   Tune40Both  = 40'ha8a2a80800;

    localparam logic [HistW-1:0] P1MaskReset    = 48'hFFFFFFFFFFFF;
    localparam logic [HistW-1:0] P1PatternReset = 48'd93965126694911;
    localparam logic [P2W-1:0]   P2MaskReset    = 40'hFFFFFFFFFF;
    localparam logic [P2W-1:0]   P2PatternReset = 40'd375228200959;
    localparam logic [RunW-1:0]  RepeatThrReset = 4'd5;

    typedef struct packed {
        logic              tdma_mode;
        logic [HistW-1:0]  p1_sync_mask;
        logic [HistW-1:0]  p1_sync_pattern;
        logic [P2W-1:0]    p2_sync_mask;
        logic [P2W-1:0]    p2_sync_pattern;
        logic [RunW-1:0]   repeat_threshold;
    } cfg_t;

    typedef struct packed {
        event_kind_t      kind;
        logic [RunW-1:0]  run;
    } event_state_t;

endpackage

/* hw/rtl/dibit_slicer_sync_tuning_detector.sv */
// An accepted item moves from the input register into the result register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready is high; an input register in front of
// the result register lets one further item be taken while a result waits on m_tready.
// Reset: aresetn is synchronous, active low; it empties both stages, clears the dibit
// history and run count, and loads the configuration registers with their defaults.
// Top level: depends on dsstd_pkg, dsstd_cfg and dsstd_core.
module dibit_slicer_sync_tuning_detector
    import dsstd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [15:0] phase_angle, [17:16] fm_sign, rest zero
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [1:0] dibit, [4:2] tune_request, rest zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic signed [15:0] phase_reg;
    logic signed [1:0]  fm_sign_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         dibit_reg;
    logic signed [2:0]  request_reg;
    logic [1:0]         dibit_c;
    logic signed [2:0]  request_c;
    logic               advance;

    dsstd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsstd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .phase_angle  (phase_reg),
        .fm_sign      (fm_sign_reg),
        .cfg          (cfg),
        .dibit        (dibit_c),
        .tune_request (request_c)
    );

    // Advance when the input register holds an item and the result register is empty or being emptied
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            phase_reg   <= s_tdata[15:0];
            fm_sign_reg <= s_tdata[17:16];
        end
        if (advance) begin
            dibit_reg   <= dibit_c;
            request_reg <= request_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, request_reg, dibit_reg};

endmodule

/* hw/rtl/dsstd_cfg.sv */
// APB-style configuration registers of the dibit slicer and sync detector.
// Depends on dsstd_pkg for the register map, reset values and cfg_t.
module dsstd_cfg
    import dsstd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = reg_index_t'(paddr[AddrW-1:3]);
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                REG_TDMA_MODE:  cfg_next.tdma_mode        = pwdata[0];
                REG_P1_MASK:    cfg_next.p1_sync_mask     = pwdata[HistW-1:0];
                REG_P1_PATTERN: cfg_next.p1_sync_pattern  = pwdata[HistW-1:0];
                REG_P2_MASK:    cfg_next.p2_sync_mask     = pwdata[P2W-1:0];
                REG_P2_PATTERN: cfg_next.p2_sync_pattern  = pwdata[P2W-1:0];
                REG_REPEAT_THR: cfg_next.repeat_threshold = pwdata[RunW-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tdma_mode        <= 1'b0;
            cfg_reg.p1_sync_mask     <= P1MaskReset;
            cfg_reg.p1_sync_pattern  <= P1PatternReset;
            cfg_reg.p2_sync_mask     <= P2MaskReset;
            cfg_reg.p2_sync_pattern  <= P2PatternReset;
            cfg_reg.repeat_threshold <= RepeatThrReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            REG_TDMA_MODE:  prdata = {{(DataW-1){1'b0}}, cfg_reg.tdma_mode};
            REG_P1_MASK:    prdata = {{(DataW-HistW){1'b0}}, cfg_reg.p1_sync_mask};
            REG_P1_PATTERN: prdata = {{(DataW-HistW){1'b0}}, cfg_reg.p1_sync_pattern};
            REG_P2_MASK:    prdata = {{(DataW-P2W){1'b0}}, cfg_reg.p2_sync_mask};
            REG_P2_PATTERN: prdata = {{(DataW-P2W){1'b0}}, cfg_reg.p2_sync_pattern};
            REG_REPEAT_THR: prdata = {{(DataW-RunW){1'b0}}, cfg_reg.repeat_threshold};
            default:        prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/dsstd_core.sv */
// Slicer, dibit history, sync/tuning pattern match and event run tracking.
// Depends on dsstd_pkg; state advances only when the top level moves an item on.
module dsstd_core
    import dsstd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic signed [15:0] phase_angle,
    input  logic signed [1:0]  fm_sign,
    input  cfg_t               cfg,
    output logic [1:0]         dibit,
    output logic signed [2:0]  tune_request
);

    logic [HistW-1:0] history_reg;
    logic [HistW-1:0] history_next;
    event_state_t     event_reg;
    event_state_t     event_mid;
    event_state_t     event_next;
    logic [HistW-1:0] h1;
    logic             sync_hit;
    logic             err_hit;
    event_kind_t      err_kind;
    logic             hit_minus;
    logic             hit_plus;
    logic             hit_both;
    logic             fm_neg;
    logic             fm_pos;
    logic             qualify;

    function automatic event_state_t note_event(event_state_t cur, event_kind_t k);
        event_state_t res;
        res = cur;
        if (cur.kind == k) begin
            if (cur.run != RunMax)
                res.run = cur.run + 1'b1;
        end else begin
            res.kind = k;
            res.run  = RunW'(1);
        end
        return res;
    endfunction

    // Quadrant slice: sign bit gives the high bit, sign xor next bit the low bit
    assign dibit        = {phase_angle[15], phase_angle[15] ^ phase_angle[14]};
    assign history_next = {history_reg[HistW-3:0], dibit};
    assign h1           = history_next & cfg.p1_sync_mask;

    assign sync_hit = (h1 == cfg.p1_sync_pattern)
                    || ((history_next[P2W-1:0] & cfg.p2_sync_mask) == cfg.p2_sync_pattern);

    always_comb begin
        if (cfg.tdma_mode) begin
            hit_minus = (h1[P2W-1:0] == Tune40Minus);
            hit_plus  = (h1[P2W-1:0] == Tune40Plus);
            hit_both  = (h1[P2W-1:0] == Tune40Both);
        end else begin
            hit_minus = (h1 == Tune48Minus);
            hit_plus  = (h1 == Tune48Plus);
            hit_both  = (h1 == Tune48Both);
        end
    end

    always_comb begin
        err_hit  = hit_minus | hit_plus | hit_both;
        if (hit_minus)
            err_kind = KIND_MINUS;
        else if (hit_plus)
            err_kind = KIND_PLUS;
        else
            err_kind = KIND_BOTH;
    end

    // Sync event first, then the tuning-error event on top of it
    assign event_mid  = sync_hit ? note_event(event_reg, KIND_SYNC) : event_reg;
    assign event_next = err_hit ? note_event(event_mid, err_kind) : event_mid;

    assign fm_neg  = fm_sign[1];
    assign fm_pos  = (fm_sign == 2'sd1);
    assign qualify = (event_next.kind != KIND_SYNC)
                   && (event_next.run >= cfg.repeat_threshold);

    always_comb begin
        tune_request = 3'sd0;
        if (qualify) begin
            case (event_next.kind)
                KIND_PLUS:  tune_request = fm_pos ? -3'sd1 : 3'sd0;
                KIND_MINUS: tune_request = fm_neg ? 3'sd1 : 3'sd0;
                KIND_BOTH:  tune_request = fm_neg ? 3'sd2 : -3'sd2;
                default:    tune_request = 3'sd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg    <= '0;
            event_reg.kind <= KIND_SYNC;
            event_reg.run  <= '0;
        end else if (advance) begin
            history_reg <= history_next;
            event_reg   <= event_next;
        end
    end

endmodule

/* hw/rtl/dsstd_checker.sv */
// Port-level checker for the dibit slicer and sync detector, bound to the top level.
// Depends on dibit_slicer_sync_tuning_detector_defines.svh for the assertion macros.
`include "dibit_slicer_sync_tuning_detector_defines.svh"

module dsstd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `DSSTD_ASSERT(a_result_held, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result transaction changed or vanished")

    // Input back-pressure only ever comes from a result waiting downstream
    `DSSTD_ASSERT(a_stall_source, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled with no result waiting")

    `DSSTD_ASSERT(a_request_range, aclk, aresetn, m_tvalid |-> (m_tdata[4:2] != 3'b011) && (m_tdata[4:2] != 3'b100) && (m_tdata[4:2] != 3'b101) && (m_tdata[7:5] == 3'b000), "tuning request out of range or padding set")

    `DSSTD_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn) |-> !m_tvalid, "result valid straight after reset")

endmodule

bind dibit_slicer_sync_tuning_detector dsstd_checker u_checker (.*);
